/* hdl/pocp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pocp_pkg - shared types and constants for periodic overlap-checked placement
// Field widths, register indexes, result codes and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package pocp_pkg;

  // Parameter defaults
  localparam int unsigned MAX_PARTICLES_DEF = 1024;
  localparam int unsigned COORD_WIDTH_DEF   = 24;

  // Fixed field widths
  localparam int unsigned BOX_W      = 24;
  localparam int unsigned CUT_W      = 48;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // Clamped axis magnitude (at most 2^24), its square and the three-term sum
  localparam int unsigned MAG_W = 25;
  localparam int unsigned SQ_W  = 2 * MAG_W;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam logic [MAG_W-1:0] DIFF_CLAMP = 25'h100_0000;

  // Register reset values
  localparam logic [BOX_W-1:0] BOX_LENGTH_RST = 24'd655360;
  localparam logic [CUT_W-1:0] CUTOFF_SQ_RST  = 48'h0001_0000_0000;
  localparam logic [CNT_W-1:0] TARGET_RST     = 11'd1024;
  localparam logic [CNT_W-1:0] FIRST_TYPE_RST = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_LENGTH       = 3'd0,
    CFG_CUTOFF_SQ        = 3'd1,
    CFG_PARTICLE_TARGET  = 3'd2,
    CFG_FIRST_TYPE_COUNT = 3'd3
  } cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_REJECT = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_cand;
    logic    rd_en;
    logic    store;
    logic    load_result;
    status_e res_status;
    logic    res_type;
    logic    res_all_placed;
  } pocp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic overlap;
  } pocp_sts_t;

endpackage
`default_nettype wire

/* hdl/periodic_overlap_checked_placement.sv */
`default_nettype none
// Accept to result: with the store empty or the target reached the controller
// goes straight to the result state; otherwise it reads one stored particle per
// cycle through the single read port of the position stores, then lets the
// pipeline drain. Candidates are taken one at a time; a waiting result does not
// block the next accept. Reset: registers to defaults, placed count zero;
// position stores are not cleared (no clearing pass, only written slots are ever read).
// ----------------------------------------------------------------------------
// periodic_overlap_checked_placement - top level
// Random sequential addition with a minimum-image overlap test in a periodic
// cubic box: config registers, placement controller and distance datapath.
// ----------------------------------------------------------------------------
module periodic_overlap_checked_placement #(
  parameter int unsigned MAX_PARTICLES = pocp_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned COORD_WIDTH   = pocp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pocp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pocp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [COORD_WIDTH-1:0]     cand_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     cand_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     cand_z_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [pocp_pkg::STATUS_W-1:0]          status_o,
  output logic [pocp_pkg::SLOT_W-1:0]            slot_index_o,
  output logic                                   particle_type_o,
  output logic                                   all_placed_o
);

  localparam int unsigned AW = $clog2(MAX_PARTICLES);

  logic [pocp_pkg::BOX_W-1:0] box_length;
  logic [pocp_pkg::CUT_W-1:0] cutoff_sq;
  logic [pocp_pkg::CNT_W-1:0] particle_target;
  logic [pocp_pkg::CNT_W-1:0] first_type_count;

  pocp_pkg::pocp_cmd_t        cmd;
  pocp_pkg::pocp_sts_t        sts;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [pocp_pkg::SLOT_W-1:0] slot;

  pocp_cfg u_cfg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .box_length_o       (box_length),
    .cutoff_sq_o        (cutoff_sq),
    .particle_target_o  (particle_target),
    .first_type_count_o (first_type_count)
  );

  pocp_ctrl #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .particle_target_i  (particle_target),
    .first_type_count_i (first_type_count),
    .sts_i              (sts),
    .cmd_o              (cmd),
    .rd_addr_o          (rd_addr),
    .wr_addr_o          (wr_addr),
    .slot_o             (slot)
  );

  pocp_dpath #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .COORD_WIDTH   (COORD_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cand_x_i        (cand_x_i),
    .cand_y_i        (cand_y_i),
    .cand_z_i        (cand_z_i),
    .box_length_i    (box_length),
    .cutoff_sq_i     (cutoff_sq),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .wr_addr_i       (wr_addr),
    .slot_i          (slot),
    .sts_o           (sts),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .particle_type_o (particle_type_o),
    .all_placed_o    (all_placed_o)
  );

endmodule
`default_nettype wire

/* hdl/pocp_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pocp_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pocp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hdl/pocp_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pocp_cfg - configuration register file
// Box length, cutoff, particle target and first-type count.
// ----------------------------------------------------------------------------
module pocp_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [pocp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pocp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic      [pocp_pkg::BOX_W-1:0]      box_length_o,
  output logic      [pocp_pkg::CUT_W-1:0]      cutoff_sq_o,
  output logic      [pocp_pkg::CNT_W-1:0]      particle_target_o,
  output logic      [pocp_pkg::CNT_W-1:0]      first_type_count_o
);

  logic [pocp_pkg::BOX_W-1:0] box_q,   box_d;
  logic [pocp_pkg::CUT_W-1:0] cut_q,   cut_d;
  logic [pocp_pkg::CNT_W-1:0] tgt_q,   tgt_d;
  logic [pocp_pkg::CNT_W-1:0] first_q, first_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    box_d   = box_q;
    cut_d   = cut_q;
    tgt_d   = tgt_q;
    first_d = first_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pocp_pkg::CFG_BOX_LENGTH:       box_d   = cfg_data_i[pocp_pkg::BOX_W-1:0];
        pocp_pkg::CFG_CUTOFF_SQ:        cut_d   = cfg_data_i[pocp_pkg::CUT_W-1:0];
        pocp_pkg::CFG_PARTICLE_TARGET:  tgt_d   = cfg_data_i[pocp_pkg::CNT_W-1:0];
        pocp_pkg::CFG_FIRST_TYPE_COUNT: first_d = cfg_data_i[pocp_pkg::CNT_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q   <= pocp_pkg::BOX_LENGTH_RST;
      cut_q   <= pocp_pkg::CUTOFF_SQ_RST;
      tgt_q   <= pocp_pkg::TARGET_RST;
      first_q <= pocp_pkg::FIRST_TYPE_RST;
    end else begin
      box_q   <= box_d;
      cut_q   <= cut_d;
      tgt_q   <= tgt_d;
      first_q <= first_d;
    end
  end

  assign box_length_o       = box_q;
  assign cutoff_sq_o        = cut_q;
  assign particle_target_o  = tgt_q;
  assign first_type_count_o = first_q;

endmodule
`default_nettype wire

/* hdl/pocp_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pocp_dpath - position stores and minimum-image distance pipeline
// Streams stored positions against the held candidate: difference, wrap,
// magnitude clamp, square, sum and cutoff compare, one stored particle a beat.
// ----------------------------------------------------------------------------
module pocp_dpath #(
  parameter int unsigned MAX_PARTICLES = pocp_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned COORD_WIDTH   = pocp_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic signed [COORD_WIDTH-1:0]        cand_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]        cand_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]        cand_z_i,
  input  wire logic        [pocp_pkg::BOX_W-1:0]    box_length_i,
  input  wire logic        [pocp_pkg::CUT_W-1:0]    cutoff_sq_i,
  input  wire pocp_pkg::pocp_cmd_t                  cmd_i,
  input  wire logic        [$clog2(MAX_PARTICLES)-1:0] rd_addr_i,
  input  wire logic        [$clog2(MAX_PARTICLES)-1:0] wr_addr_i,
  input  wire logic        [pocp_pkg::SLOT_W-1:0]   slot_i,
  output pocp_pkg::pocp_sts_t                       sts_o,
  output logic             [pocp_pkg::STATUS_W-1:0] status_o,
  output logic             [pocp_pkg::SLOT_W-1:0]   slot_index_o,
  output logic                                      particle_type_o,
  output logic                                      all_placed_o
);

  localparam int unsigned WIDER = (COORD_WIDTH > pocp_pkg::BOX_W) ? COORD_WIDTH
                                                                  : pocp_pkg::BOX_W;
  localparam int unsigned DW    = WIDER + 2;
  localparam int unsigned MAG_W = pocp_pkg::MAG_W;
  localparam int unsigned SQ_W  = pocp_pkg::SQ_W;
  localparam int unsigned SUM_W = pocp_pkg::SUM_W;
  localparam int unsigned NAX   = 3;

  logic signed [COORD_WIDTH-1:0] cand_in [NAX];
  logic signed [COORD_WIDTH-1:0] cand_q  [NAX];
  logic        [COORD_WIDTH-1:0] rd_data [NAX];

  logic signed [DW-1:0]    diff_q [NAX];
  logic signed [DW-1:0]    diff_d [NAX];
  logic signed [DW-1:0]    wrap_q [NAX];
  logic signed [DW-1:0]    wrap_d [NAX];
  logic        [MAG_W-1:0] mag_q  [NAX];
  logic        [MAG_W-1:0] mag_d  [NAX];
  logic        [SQ_W-1:0]  sq_q   [NAX];
  logic        [SQ_W-1:0]  sq_d   [NAX];

  logic [4:0]       vld_q;
  logic             overlap_q;
  logic [SUM_W-1:0] dist_sq;

  logic signed [DW:0]   len_p;
  logic signed [DW:0]   len_n;
  logic signed [DW-1:0] len_w;

  logic [pocp_pkg::STATUS_W-1:0] status_q;
  logic [pocp_pkg::SLOT_W-1:0]   slot_q;
  logic                          type_q;
  logic                          all_q;

  assign cand_in[0] = cand_x_i;
  assign cand_in[1] = cand_y_i;
  assign cand_in[2] = cand_z_i;

  for (genvar g = 0; g < NAX; g++) begin : g_store
    pocp_ram #(
      .WIDTH (COORD_WIDTH),
      .DEPTH (MAX_PARTICLES)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.store),
      .waddr_i (wr_addr_i),
      .wdata_i (cand_q[g]),
      .re_i    (cmd_i.rd_en),
      .raddr_i (rd_addr_i),
      .rdata_o (rd_data[g])
    );
  end

  assign len_p = $signed((DW + 1)'(box_length_i));
  assign len_n = -len_p;
  assign len_w = $signed(DW'(box_length_i));

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      diff_d[k] = $signed({{(DW - COORD_WIDTH){cand_q[k][COORD_WIDTH-1]}}, cand_q[k]})
                - $signed({{(DW - COORD_WIDTH){rd_data[k][COORD_WIDTH-1]}}, rd_data[k]});
    end
  end

  // Minimum image: one wrap by the box length when beyond half the box
  always_comb begin
    logic signed [DW:0] twice;
    for (int k = 0; k < NAX; k++) begin
      twice = $signed({diff_q[k], 1'b0});
      if (twice > len_p) begin
        wrap_d[k] = diff_q[k] - len_w;
      end else if (twice < len_n) begin
        wrap_d[k] = diff_q[k] + len_w;
      end else begin
        wrap_d[k] = diff_q[k];
      end
    end
  end

  always_comb begin
    logic [DW-1:0] mag_full;
    for (int k = 0; k < NAX; k++) begin
      mag_full = wrap_q[k][DW-1] ? DW'(-wrap_q[k]) : DW'(wrap_q[k]);
      if (mag_full > DW'(pocp_pkg::DIFF_CLAMP)) begin
        mag_d[k] = pocp_pkg::DIFF_CLAMP;
      end else begin
        mag_d[k] = mag_full[MAG_W-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NAX; k++) begin
      sq_d[k] = mag_q[k] * mag_q[k];
    end
  end

  assign dist_sq = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NAX; k++) begin
      if (cmd_i.load_cand) begin
        cand_q[k] <= cand_in[k];
      end
      diff_q[k] <= diff_d[k];
      wrap_q[k] <= wrap_d[k];
      mag_q[k]  <= mag_d[k];
      sq_q[k]   <= sq_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      overlap_q <= 1'b0;
    end else begin
      vld_q <= {vld_q[3:0], cmd_i.rd_en};
      if (cmd_i.load_cand) begin
        overlap_q <= 1'b0;
      end else if (vld_q[4] && (dist_sq < SUM_W'(cutoff_sq_i))) begin
        overlap_q <= 1'b1;
      end
    end
  end

  assign sts_o.busy    = |vld_q;
  assign sts_o.overlap = overlap_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_q <= cmd_i.res_status;
      slot_q   <= slot_i;
      type_q   <= cmd_i.res_type;
      all_q    <= cmd_i.res_all_placed;
    end
  end

  assign status_o        = status_q;
  assign slot_index_o    = slot_q;
  assign particle_type_o = type_q;
  assign all_placed_o    = all_q;

endmodule
`default_nettype wire

/* hdl/pocp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pocp_ctrl - placement controller
// Accepts a candidate, sweeps the stored particles, waits for the distance
// pipeline to drain and issues the result beat; owns the placed count.
// ----------------------------------------------------------------------------
module pocp_ctrl #(
  parameter int unsigned MAX_PARTICLES = pocp_pkg::MAX_PARTICLES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  input  wire logic [pocp_pkg::CNT_W-1:0]        particle_target_i,
  input  wire logic [pocp_pkg::CNT_W-1:0]        first_type_count_i,
  input  wire pocp_pkg::pocp_sts_t               sts_i,
  output pocp_pkg::pocp_cmd_t                    cmd_o,
  output logic [$clog2(MAX_PARTICLES)-1:0]       rd_addr_o,
  output logic [$clog2(MAX_PARTICLES)-1:0]       wr_addr_o,
  output logic [pocp_pkg::SLOT_W-1:0]            slot_o
);

  localparam int unsigned AW = $clog2(MAX_PARTICLES);
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned XW = (CW > pocp_pkg::CNT_W) ? CW : pocp_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  cnt_q,   cnt_d;
  logic [AW-1:0]  scan_q,  scan_d;
  logic           full_q,  full_d;
  logic           out_valid_q, out_valid_d;

  logic [XW-1:0]  max_x;
  logic [XW-1:0]  tgt_x;
  logic [XW-1:0]  eff_x;
  logic [XW-1:0]  cnt_x;
  logic [CW-1:0]  cnt_inc;
  logic           at_target;
  logic           all_after;
  logic           type_b;
  logic           scan_last;
  logic           out_free;

  assign max_x     = XW'(MAX_PARTICLES);
  assign tgt_x     = XW'(particle_target_i);
  assign eff_x     = (tgt_x > max_x) ? max_x : tgt_x;
  assign cnt_x     = XW'(cnt_q);
  assign cnt_inc   = cnt_q + 1'b1;
  assign at_target = (cnt_x >= eff_x);
  assign all_after = (XW'(cnt_inc) >= eff_x);
  assign type_b    = !(cnt_x < XW'(first_type_count_i));
  assign scan_last = (scan_q == AW'(cnt_q - 1'b1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    scan_d      = scan_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    slot_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_cand = 1'b1;
          full_d          = at_target;
          scan_d          = '0;
          if (at_target || (cnt_q == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (scan_last) begin
          state_d = S_DRAIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!sts_i.busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_result = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
          if (full_q) begin
            cmd_o.res_status     = pocp_pkg::ST_FULL;
            cmd_o.res_all_placed = 1'b1;
          end else if (sts_i.overlap) begin
            cmd_o.res_status     = pocp_pkg::ST_REJECT;
            cmd_o.res_all_placed = at_target;
          end else begin
            cmd_o.res_status     = pocp_pkg::ST_ACCEPT;
            cmd_o.store          = 1'b1;
            cmd_o.res_type       = type_b;
            cmd_o.res_all_placed = all_after;
            slot_o               = pocp_pkg::SLOT_W'(cnt_q);
            cnt_d                = cnt_inc;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      scan_q      <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      scan_q      <= scan_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign rd_addr_o   = scan_q;
  assign wr_addr_o   = cnt_q[AW-1:0];

`ifndef SYNTHESIS
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= max_x)
    else $error("placed count beyond store capacity");

  a_read_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (CW'(scan_q) < cnt_q))
    else $error("read of a slot that was never written");

  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> (cmd_o.load_result && !full_q && !sts_i.overlap && !sts_i.busy))
    else $error("store without a clean finished scan");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_result |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("loaded result not presented");
`endif

endmodule
`default_nettype wire

/* verif/pocp_checker.sv */
// ----------------------------------------------------------------------------
// pocp_checker - placement predictor and result comparator
// Watches the register, candidate and result channels of the placement block.
// Keeps its own copy of the registers and of the stored positions, predicts
// one placement outcome per accepted candidate and compares every result
// beat against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pocp_checker #(
  parameter int unsigned MAX_PARTICLES = pocp_pkg::MAX_PARTICLES_DEF,
  parameter int unsigned COORD_WIDTH   = pocp_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [pocp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pocp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [COORD_WIDTH-1:0]       cand_x_i,
  input  logic signed [COORD_WIDTH-1:0]       cand_y_i,
  input  logic signed [COORD_WIDTH-1:0]       cand_z_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [pocp_pkg::STATUS_W-1:0]       status_i,
  input  logic [pocp_pkg::SLOT_W-1:0]         slot_index_i,
  input  logic                                particle_type_i,
  input  logic                                all_placed_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  placed_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pocp_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic              ptype;
    logic              all_placed;
  } placement_t;

  localparam longint AXIS_CLAMP = 64'sd16777216;

  logic [BOX_W-1:0] box_len;
  logic [CUT_W-1:0] cut_sq;
  logic [CNT_W-1:0] target;
  logic [CNT_W-1:0] type_split;

  coord_t      pos_x [MAX_PARTICLES];
  coord_t      pos_y [MAX_PARTICLES];
  coord_t      pos_z [MAX_PARTICLES];
  int unsigned placed;
  int          mismatches;
  placement_t  placement_q[$];
  placement_t  oldest;

  // Squared minimum-image distance along one axis, at most one wrap.
  function automatic longint unsigned axis_sq(coord_t a, coord_t b);
    longint d;
    longint len;
    d   = longint'(a) - longint'(b);
    len = longint'(box_len);
    if (2 * d > len) begin
      d -= len;
    end else if (2 * d < -len) begin
      d += len;
    end
    if (d < 0) d = -d;
    if (d > AXIS_CLAMP) d = AXIS_CLAMP;
    return d * d;
  endfunction

  // Unless full, scan the stored positions up to the first overlap, then place the candidate or turn it away.
  function automatic placement_t place_candidate(coord_t cx, coord_t cy, coord_t cz);
    placement_t       res;
    int unsigned      lim;
    longint unsigned  r2;
    bit               hit;
    lim = (target > MAX_PARTICLES) ? MAX_PARTICLES : target;
    res.status     = ST_REJECT;
    res.slot       = '0;
    res.ptype      = 1'b0;
    res.all_placed = 1'b0;
    hit            = 1'b0;
    if (placed >= lim) begin
      res.status = ST_FULL;
    end else begin
      for (int unsigned j = 0; j < placed && !hit; j++) begin
        r2 = axis_sq(cx, pos_x[j]) + axis_sq(cy, pos_y[j]) + axis_sq(cz, pos_z[j]);
        if (r2 < 64'(cut_sq)) hit = 1'b1;
      end
      if (!hit) begin
        pos_x[placed] = cx;
        pos_y[placed] = cy;
        pos_z[placed] = cz;
        res.status    = ST_ACCEPT;
        res.slot      = SLOT_W'(placed);
        res.ptype     = (placed >= type_split);
        placed++;
      end
    end
    res.all_placed = (placed >= lim);
    return res;
  endfunction

  function automatic void check_field(string what, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_len    = BOX_LENGTH_RST;
      cut_sq     = CUTOFF_SQ_RST;
      target     = TARGET_RST;
      type_split = FIRST_TYPE_RST;
      placed     = 0;
      mismatches = 0;
      placement_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      placed_o     <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BOX_LENGTH:       box_len    = cfg_data_i[BOX_W-1:0];
          CFG_CUTOFF_SQ:        cut_sq     = cfg_data_i[CUT_W-1:0];
          CFG_PARTICLE_TARGET:  target     = cfg_data_i[CNT_W-1:0];
          CFG_FIRST_TYPE_COUNT: type_split = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        placement_q = {placement_q, place_candidate(cand_x_i, cand_y_i, cand_z_i)};
      end
      if (out_valid_i && !out_stall_i) begin
        if (placement_q.size() == 0) begin
          $display("%0t ns: result beat with nothing outstanding, expected none, actual status %0d",
                   $time, status_i);
          mismatches++;
        end else begin
          oldest = placement_q.pop_front();
          check_field("status", oldest.status, status_i);
          check_field("slot_index", oldest.slot, slot_index_i);
          check_field("particle_type", oldest.ptype, particle_type_i);
          check_field("all_placed", oldest.all_placed, all_placed_i);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= placement_q.size();
      placed_o     <= placed;
    end
  end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb - testbench top for periodic overlap-checked placement
// Drives register setups and candidate positions: a directed opening on the
// wrap, boundary, target and type-split corners, then random phases mixing
// fresh positions, near copies and periodic images of earlier candidates,
// under changing sender and receiver idling. Checking lives in pocp_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pocp_pkg::*;

  localparam int unsigned NPART  = MAX_PARTICLES_DEF;
  localparam int unsigned CW     = COORD_WIDTH_DEF;
  localparam int          C_MAX  = 8388607;
  localparam int          C_MIN  = -8388608;
  localparam int          HOLD_CYCLES = 2500;
  localparam int          HISTORY     = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;
  localparam logic [CUT_W-1:0]     CUT_ONE       = 48'h0001_0000_0000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } cand_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  coord_t                cand_x;
  coord_t                cand_y;
  coord_t                cand_z;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   status;
  logic [SLOT_W-1:0]     slot_index;
  logic                  particle_type;
  logic                  all_placed;

  int fail_count;
  int pending;
  int placed;

  int               send_pct;
  int               recv_pct;
  bit               hold_req;
  logic [BOX_W-1:0] cur_box;
  int               cur_jit;
  cand_t            sent_q[$];
  int               items_sent;
  int               setups;

  periodic_overlap_checked_placement #(
    .MAX_PARTICLES (NPART),
    .COORD_WIDTH   (CW)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cand_x_i        (cand_x),
    .cand_y_i        (cand_y),
    .cand_z_i        (cand_z),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .slot_index_o    (slot_index),
    .particle_type_o (particle_type),
    .all_placed_o    (all_placed)
  );

  pocp_checker #(
    .MAX_PARTICLES (NPART),
    .COORD_WIDTH   (CW)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cand_x_i        (cand_x),
    .cand_y_i        (cand_y),
    .cand_z_i        (cand_z),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .slot_index_i    (slot_index),
    .particle_type_i (particle_type),
    .all_placed_i    (all_placed),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .placed_o        (placed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stall, or one long hold-off when asked.
  initial begin
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("[periodic_overlap_checked_placement] ERROR");
    $finish;
  end

  function automatic cand_t point(int x, int y, int z);
    cand_t c;
    c.x = coord_t'(x);
    c.y = coord_t'(y);
    c.z = coord_t'(z);
    return c;
  endfunction

  function automatic int jitter();
    return int'($urandom_range(2 * cur_jit)) - cur_jit;
  endfunction

  function automatic int image_shift();
    int shift;
    shift = 0;
    if ($urandom_range(1) == 1) shift = ($urandom_range(1) == 1) ? int'(cur_box) : -int'(cur_box);
    return shift;
  endfunction

  // Mostly fresh positions inside the half box; the rest land near an earlier
  // candidate, near one of its periodic images, or anywhere in the field.
  function automatic cand_t make_candidate();
    cand_t       c;
    cand_t       p;
    int unsigned pick;
    int          half;
    pick = $urandom_range(99);
    half = int'(cur_box) / 2;
    c.x  = coord_t'(int'($urandom_range(cur_box)) - half);
    c.y  = coord_t'(int'($urandom_range(cur_box)) - half);
    c.z  = coord_t'(int'($urandom_range(cur_box)) - half);
    if (sent_q.size() != 0 && pick >= 55 && pick < 92) begin
      p   = sent_q[$urandom_range(sent_q.size() - 1)];
      c.x = coord_t'(int'(p.x) + jitter() + ((pick >= 80) ? image_shift() : 0));
      c.y = coord_t'(int'(p.y) + jitter() + ((pick >= 80) ? image_shift() : 0));
      c.z = coord_t'(int'(p.z) + jitter() + ((pick >= 80) ? image_shift() : 0));
    end else if (pick >= 92) begin
      c.x = coord_t'($urandom);
      c.y = coord_t'($urandom);
      c.z = coord_t'($urandom);
    end
    return c;
  endfunction

  task automatic send_cand(input cand_t c);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    cand_x   <= c.x;
    cand_y   <= c.y;
    cand_z   <= c.z;
    sent_q = {sent_q, c};
    if (sent_q.size() > HISTORY) void'(sent_q.pop_front());
    items_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every outstanding result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers; junk above the box, target and split widths must be dropped.
  task automatic apply_setup(input logic [BOX_W-1:0] box, input logic [CUT_W-1:0] cut,
                             input int unsigned tgt, input int unsigned split, input int jit);
    write_reg(CFG_BOX_LENGTH, {24'($urandom), box});
    write_reg(CFG_CUTOFF_SQ, cut);
    write_reg(CFG_PARTICLE_TARGET, {37'($urandom), CNT_W'(tgt)});
    write_reg(CFG_FIRST_TYPE_COUNT, {37'($urandom), CNT_W'(split)});
    cfg_valid <= 1'b0;
    cur_box = box;
    cur_jit = jit;
    setups++;
  endtask

  task automatic run_random(input int n, input int hold_at, input int pause_at);
    for (int k = 0; k < n; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain();
      send_cand(make_candidate());
    end
  endtask

  initial begin
    logic [BOX_W-1:0] box;
    int               jit;
    rst_n      <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    cand_x     <= '0;
    cand_y     <= '0;
    cand_z     <= '0;
    hold_req   = 1'b0;
    send_pct   = 6;
    recv_pct   = 85;
    cur_box    = BOX_LENGTH_RST;
    cur_jit    = 65536;
    items_sent = 0;
    setups     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: box 10.0, cutoff 1.0.
    send_cand(point(0, 0, 0));
    send_cand(point(0, 0, 0));                  // exact duplicate
    send_cand(point(327680, 0, 0));             // exactly half a box away, no wrap
    send_cand(point(-294912, 0, 0));            // overlaps only through the wrap
    send_cand(point(C_MAX, C_MIN, C_MAX));
    send_cand(point(C_MIN, C_MAX, C_MIN));
    send_cand(point(671744, 0, 0));             // outside the half box, wraps onto origin
    drain();

    // Unknown index must be dropped; then largest cutoff rejects everything.
    write_reg(CFG_SPARE_IDX, '1);
    apply_setup('0, '1, 2047, 0, 0);
    send_cand(point(C_MIN, C_MIN, C_MIN));
    drain();

    // Zero cutoff and zero box: duplicates and far points all go in as type 1.
    apply_setup('0, '0, 2047, 0, 0);
    send_cand(point(0, 0, 0));
    send_cand(point(655360, 0, 0));
    drain();

    // Zero target: full at once.
    apply_setup('1, '0, 0, 0, 0);
    send_cand(point(1, 2, 3));
    send_cand(point(C_MAX, C_MAX, C_MAX));
    drain();

    // Target below the current count.
    apply_setup(24'd1, CUT_ONE, 3, 1024, 0);
    send_cand(point(-5, 7, 11));
    drain();

    // Cross the type split and reach the target exactly.
    apply_setup(BOX_LENGTH_RST, '0, placed + 2, placed + 1, 65536);
    send_cand(point(100, 200, 300));
    send_cand(point(-100, -200, -300));
    send_cand(point(0, 0, 0));
    drain();

    // Random, receiver mostly stalled, one long hold-off.
    apply_setup(BOX_LENGTH_RST, CUT_ONE, 2047, placed + 60, 65536);
    run_random(150, 60, -1);
    drain();

    // Random, sender mostly idle, random box and split.
    send_pct = 85;
    recv_pct = 6;
    box = BOX_W'($urandom_range(4194304, 131072));
    jit = int'(box) / 16;
    apply_setup(box, CUT_W'(longint'(jit) * jit), 1024, $urandom_range(2047), jit);
    run_random(150, -1, -1);
    drain();

    // No idling: largest box, fill to a nearby target, pause once mid-run.
    send_pct = 0;
    recv_pct = 0;
    jit = 16777215 / 16;
    apply_setup('1, CUT_W'(longint'(jit) * jit), placed + $urandom_range(40, 20),
                placed + 10, jit);
    run_random(70, -1, 35);
    drain();

    box = BOX_W'($urandom_range(16777215, 1));
    jit = (int'(box) / 16 > 0) ? int'(box) / 16 : 1;
    apply_setup(box, CUT_W'(longint'(jit) * jit), 1024, placed, jit);
    run_random(80, -1, -1);
    drain();

    repeat (placed + 16) @(posedge clk);
    $display("Sent %0d candidates under %0d register setups; %0d particles placed.",
             items_sent, setups, placed);
    if (fail_count == 0 && pending == 0) begin
      $display("[periodic_overlap_checked_placement] OK");
    end else begin
      $display("[periodic_overlap_checked_placement] ERROR");
    end
    $finish;
  end

endmodule
